// File: rtl/iir_lowpass_order6_assert.svh
// Assertion macros for the sixth-order low-pass filter.
// Used by iir_lowpass_order6.sv; the macros expand to nothing when SYNTHESIS is set.
`ifndef IIR_LOWPASS_ORDER6_ASSERT_SVH
`define IIR_LOWPASS_ORDER6_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked outside reset
`define IIR6_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("iir6 same-cycle check failed");
// next-cycle implication, checked outside reset
`define IIR6_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("iir6 next-cycle check failed");
`else
`define IIR6_ASSERT_SAME(label, ante, cons)
`define IIR6_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: rtl/iir6_pkg.sv
// Shared constants, types and coefficient table of the sixth-order low-pass filter.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none
package iir6_pkg;

  localparam int FILTER_ORDER    = 6;
  localparam int COEFF_FRAC_BITS = 35;
  localparam int HIST_FRAC_BITS  = 24;

  // data widths
  localparam int SAMPLE_W = 16;
  localparam int HIST_W   = 48;
  localparam int COEF_W   = COEFF_FRAC_BITS + 5;      // sign + 4 integer bits
  localparam int Y_SPLIT  = HIST_W / 2;               // history word is multiplied in halves
  localparam int OPB_W    = Y_SPLIT + 1;
  localparam int PROD_W   = COEF_W + OPB_W;
  localparam int ACC_W    = PROD_W + Y_SPLIT + 3;     // head room for thirteen terms
  localparam int YW_W     = ACC_W - COEFF_FRAC_BITS;  // rounded sum before saturation
  localparam int Q_W      = HIST_W + 1 - HIST_FRAC_BITS;
  localparam int HIDX_W   = $clog2(FILTER_ORDER);

  // step sequence: b0..b6 first, then a1..a6 as low half and high half of y
  localparam int B_STEPS   = FILTER_ORDER + 1;
  localparam int NUM_STEPS = B_STEPS + 2 * FILTER_ORDER;
  localparam int STEP_W    = $clog2(NUM_STEPS);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [HIST_W-1:0]   hist_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic [STEP_W-1:0]          step_t;

  localparam step_t STEP_FIRST = '0;
  localparam step_t STEP_LAST  = STEP_W'(NUM_STEPS - 1);
  localparam step_t STEP_A0    = STEP_W'(B_STEPS);

  localparam hist_t HIST_MAX = {1'b0, {(HIST_W-1){1'b1}}};
  localparam hist_t HIST_MIN = {1'b1, {(HIST_W-1){1'b0}}};
  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_ROUND,
    ST_OUT
  } state_t;

  // how a product is aligned before it enters the accumulator
  typedef enum logic [1:0] {
    SH_NONE,
    SH_HIST,
    SH_SPLIT
  } shift_t;

  typedef struct packed {
    logic  start;   // latch sample, clear accumulator
    logic  issue;   // multiply for the current step
    step_t step;
    logic  round;   // round and saturate the sum
    logic  commit;  // update histories, load output register
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

  // decimal coefficients scaled by 10^18
  localparam logic [63:0] DEC_SCALE = 64'd1000000000000000000;

  // decimal magnitude to fixed point, rounded to nearest (elaboration only)
  function automatic coef_t to_fixed(input logic [63:0] mag, input logic neg);
    logic [63:0] q;
    logic [63:0] r;
    q = mag / DEC_SCALE;
    r = mag % DEC_SCALE;
    for (int i = 0; i < COEFF_FRAC_BITS; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= DEC_SCALE) begin
        q = q | 64'd1;
        r = r - DEC_SCALE;
      end
    end
    r = r << 1;
    if (r >= DEC_SCALE) q = q + 64'd1;
    if (neg) q = 64'd0 - q;
    return q[COEF_W-1:0];
  endfunction

  localparam coef_t COEF_A1 = to_fixed(64'd4652613391863910000, 1'b1);
  localparam coef_t COEF_A2 = to_fixed(64'd9141129478746480000, 1'b0);
  localparam coef_t COEF_A3 = to_fixed(64'd9688720723376300000, 1'b1);
  localparam coef_t COEF_A4 = to_fixed(64'd5834464028965880000, 1'b0);
  localparam coef_t COEF_A5 = to_fixed(64'd1890599598988710000, 1'b1);
  localparam coef_t COEF_A6 = to_fixed(64'd257315928152397000, 1'b0);
  localparam coef_t COEF_B0 = to_fixed(64'd15245650559915, 1'b0);
  localparam coef_t COEF_B1 = to_fixed(64'd91473903359488, 1'b0);
  localparam coef_t COEF_B2 = to_fixed(64'd228684758398720, 1'b0);
  localparam coef_t COEF_B3 = to_fixed(64'd304913011198293, 1'b0);

  // coefficient used at each step of the sequence
  function automatic coef_t coef_of(input step_t s);
    coef_t c;
    c = '0;
    case (s)
      5'd0, 5'd6:   c = COEF_B0;
      5'd1, 5'd5:   c = COEF_B1;
      5'd2, 5'd4:   c = COEF_B2;
      5'd3:         c = COEF_B3;
      5'd7, 5'd8:   c = COEF_A1;
      5'd9, 5'd10:  c = COEF_A2;
      5'd11, 5'd12: c = COEF_A3;
      5'd13, 5'd14: c = COEF_A4;
      5'd15, 5'd16: c = COEF_A5;
      5'd17, 5'd18: c = COEF_A6;
      default:      c = '0;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// File: rtl/iir6_ctrl.sv
// Sequencer of the filter: steps the shared multiplier through the thirteen terms.
// Depends on iir6_pkg (state, command and status types).
`default_nettype none
module iir6_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire iir6_pkg::sts_t sts,
  output iir6_pkg::cmd_t     cmd
);
  import iir6_pkg::*;

  state_t state_r, state_nxt;
  step_t  step_r, step_nxt;

  // state and step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= STEP_FIRST;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    step_nxt  = STEP_FIRST;
    unique case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_MAC;
      ST_MAC: begin
        if (step_r == STEP_LAST) begin
          state_nxt = ST_DRAIN;
        end else begin
          step_nxt = step_r + step_t'(1);
        end
      end
      ST_DRAIN: state_nxt = ST_ROUND;
      ST_ROUND: state_nxt = ST_OUT;
      ST_OUT:   if (sts.out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    in_stall   = (state_r != ST_IDLE);
    cmd.start  = (state_r == ST_IDLE) && in_valid;
    cmd.issue  = (state_r == ST_MAC);
    cmd.step   = step_r;
    cmd.round  = (state_r == ST_ROUND);
    cmd.commit = (state_r == ST_OUT) && sts.out_free;
  end

endmodule
`default_nettype wire

// File: rtl/iir6_dp.sv
// Datapath of the filter: histories, shared multiplier, accumulator, rounding, output register.
// Depends on iir6_pkg (widths, coefficient table, command and status types).
`default_nettype none
module iir6_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire iir6_pkg::sample_t in_sample_in,
  input  wire iir6_pkg::cmd_t    cmd,
  output iir6_pkg::sts_t         sts,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output iir6_pkg::sample_t      out_sample_out,
  output logic                   out_clipped
);
  import iir6_pkg::*;

  sample_t x_in_r;
  sample_t xh_r [FILTER_ORDER];
  hist_t   yh_r [FILTER_ORDER];

  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  shift_t                   prod_sh_r, prod_sh_nxt;
  logic                     prod_neg_r, prod_neg_nxt;
  logic                     prod_vld_r;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt, term;

  hist_t y_r, y_nxt;
  logic  hclip_r, hclip_nxt;

  logic    out_valid_r;
  sample_t out_sample_r, out_sample_nxt;
  logic    out_clip_r, out_clip_nxt;

  // operand selection
  coef_t                   coef_op;
  logic signed [OPB_W-1:0] opb;
  logic [HIDX_W-1:0]       xidx, yidx;
  step_t                   a_off;

  always_comb begin
    coef_op      = coef_of(cmd.step);
    opb          = '0;
    xidx         = '0;
    yidx         = '0;
    a_off        = cmd.step - STEP_A0;
    prod_sh_nxt  = SH_NONE;
    prod_neg_nxt = 1'b0;
    if (cmd.step < STEP_A0) begin
      // feed-forward terms: current sample, then input history
      xidx        = HIDX_W'(cmd.step - step_t'(1));
      opb         = (cmd.step == STEP_FIRST) ? OPB_W'(x_in_r) : OPB_W'(xh_r[xidx]);
      prod_sh_nxt = SH_HIST;
    end else begin
      // feedback terms: low half unsigned, high half signed, subtracted
      yidx         = HIDX_W'(a_off >> 1);
      prod_neg_nxt = 1'b1;
      if (a_off[0]) begin
        opb         = OPB_W'($signed(yh_r[yidx][HIST_W-1:Y_SPLIT]));
        prod_sh_nxt = SH_SPLIT;
      end else begin
        opb = $signed({1'b0, yh_r[yidx][Y_SPLIT-1:0]});
      end
    end
    prod_nxt = PROD_W'(coef_op) * PROD_W'(opb);
  end

  // product register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      prod_r     <= prod_nxt;
      prod_sh_r  <= prod_sh_nxt;
      prod_neg_r <= prod_neg_nxt;
    end
  end

  // accumulate the registered product
  always_comb begin
    unique case (prod_sh_r)
      SH_NONE:  term = ACC_W'(prod_r);
      SH_HIST:  term = ACC_W'(prod_r) <<< HIST_FRAC_BITS;
      SH_SPLIT: term = ACC_W'(prod_r) <<< Y_SPLIT;
      default:  term = ACC_W'(prod_r);
    endcase
    acc_nxt = prod_neg_r ? (acc_r - term) : (acc_r + term);
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      acc_r  <= '0;
      x_in_r <= in_sample_in;
    end else if (prod_vld_r) begin
      acc_r <= acc_nxt;
    end
  end

  // round the sum to history precision and saturate to 48 bits
  localparam logic [ACC_W-1:0] ACC_HALF = ACC_W'(1) << (COEFF_FRAC_BITS - 1);
  logic signed [ACC_W-1:0] rsum;
  logic [YW_W-1:0]         ywide;
  logic [YW_W-HIST_W:0]    ytop;

  always_comb begin
    rsum      = acc_r + $signed(ACC_HALF);
    ywide     = rsum[ACC_W-1:COEFF_FRAC_BITS];
    ytop      = ywide[YW_W-1:HIST_W-1];
    hclip_nxt = !((&ytop) || !(|ytop));
    if (hclip_nxt) begin
      y_nxt = ywide[YW_W-1] ? HIST_MIN : HIST_MAX;
    end else begin
      y_nxt = ywide[HIST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.round) begin
      y_r     <= y_nxt;
      hclip_r <= hclip_nxt;
    end
  end

  // output sample: round half up to integer, saturate to 16 bits
  localparam logic [HIST_W:0] Y_HALF = (HIST_W+1)'(1) << (HIST_FRAC_BITS - 1);
  logic [HIST_W:0]          yt;
  logic [Q_W-1:0]           qv;
  logic [Q_W-SAMPLE_W:0]    qtop;
  logic                     qclip;

  always_comb begin
    yt    = {y_r[HIST_W-1], y_r} + Y_HALF;
    qv    = yt[HIST_W:HIST_FRAC_BITS];
    qtop  = qv[Q_W-1:SAMPLE_W-1];
    qclip = !((&qtop) || !(|qtop));
    if (qclip) begin
      out_sample_nxt = qv[Q_W-1] ? SAMPLE_MIN : SAMPLE_MAX;
    end else begin
      out_sample_nxt = qv[SAMPLE_W-1:0];
    end
    out_clip_nxt = qclip || hclip_r;
  end

  // histories shift on commit, newest first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FILTER_ORDER; i++) begin
        xh_r[i] <= '0;
        yh_r[i] <= '0;
      end
    end else if (cmd.commit) begin
      for (int i = FILTER_ORDER - 1; i > 0; i--) begin
        xh_r[i] <= xh_r[i-1];
        yh_r[i] <= yh_r[i-1];
      end
      xh_r[0] <= x_in_r;
      yh_r[0] <= y_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_sample_r <= out_sample_nxt;
      out_clip_r   <= out_clip_nxt;
    end
  end

  assign sts.out_free    = !out_valid_r || !out_stall;
  assign out_valid       = out_valid_r;
  assign out_sample_out  = out_sample_r;
  assign out_clipped     = out_clip_r;

endmodule
`default_nettype wire

// File: rtl/iir_lowpass_order6.sv
// Sixth-order Butterworth low-pass filter, direct form I, fixed-point coefficients.
// Top level: joins iir6_ctrl and iir6_dp; depends on iir6_pkg and iir_lowpass_order6_assert.svh.
//
// Usage:
//   Input channel in_valid / in_stall carries one signed 16-bit sample per item.
//   Output channel out_valid / out_stall returns one filtered sample per item
//   plus a clipped flag (history or output saturation happened on this item).
//   An item moves on a rising edge with valid high and stall low.
// Timing:
//   One 40x25-bit multiplier is shared over 19 steps per item: seven
//   feed-forward products and six feedback products split into two halves each.
//   A new item is taken only while the block is idle, after the previous item
//   has been committed; each item runs that multiplier sequence, then the drain,
//   round and commit steps.
//   A finished item sits in the output register while the next item is taken
//   and computed; if the receiver still stalls when the next item is done, the
//   block holds in its commit step until the output register frees up.
// Reset:
//   Synchronous, active low. Both histories clear to zero, no item in flight.
`default_nettype none
module iir_lowpass_order6 (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire iir6_pkg::sample_t in_sample_in,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output iir6_pkg::sample_t      out_sample_out,
  output logic                   out_clipped
);
  import iir6_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  iir6_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // arithmetic and storage
  iir6_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_sample_in   (in_sample_in),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample_out (out_sample_out),
    .out_clipped    (out_clipped)
  );

  // checks
  `include "iir_lowpass_order6_assert.svh"

  `IIR6_ASSERT_NEXT(a_start_seq, in_valid && !in_stall, cmd.issue && (cmd.step == STEP_FIRST))
  `IIR6_ASSERT_SAME(a_commit_free, cmd.commit, sts.out_free)
  `IIR6_ASSERT_NEXT(a_commit_out, cmd.commit, out_valid)
  `IIR6_ASSERT_SAME(a_busy_stall, cmd.issue, in_stall)

endmodule
`default_nettype wire

// File: dv/iir6_checker.sv
// Checker for the sixth-order low-pass filter: watches both channels, predicts
// every filtered sample bit for bit and compares. Depends on iir6_pkg for types.
`timescale 1ns / 100ps
module iir6_checker
  import iir6_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_stall,
  input  sample_t in_sample_in,
  input  logic    out_valid,
  input  logic    out_stall,
  input  sample_t out_sample_out,
  input  logic    out_clipped,
  output int      fail_count,
  output int      pending,
  output int      results_checked,
  output int      clip_count
);

  typedef struct packed {
    sample_t value;
    logic    clipped;
  } filtered_t;

  localparam logic [63:0] TEN18 = 64'd1000000000000000000;
  localparam logic signed [127:0] HIST_TOP = (128'sd1 <<< (HIST_W - 1)) - 128'sd1;
  localparam logic signed [127:0] HIST_BOTTOM = -(128'sd1 <<< (HIST_W - 1));
  localparam logic signed [63:0] OUT_TOP = 64'sd32767;
  localparam logic signed [63:0] OUT_BOTTOM = -64'sd32768;

  filtered_t due_samples[$];

  // Q4.35 coefficients, our own conversion from the decimal values
  logic signed [63:0] ff_coef [0:FILTER_ORDER];
  logic signed [63:0] fb_coef [1:FILTER_ORDER];

  // filter memory, newest first
  sample_t            x_hist [0:FILTER_ORDER-1];
  logic signed [47:0] y_hist [0:FILTER_ORDER-1];

  // decimal magnitude scaled by 1e18 -> fixed point, nearest, ties away from zero
  function automatic logic signed [63:0] to_q35(input logic [63:0] mag, input logic neg);
    logic [127:0] num;
    logic [127:0] q;
    num = ({64'd0, mag} << (COEFF_FRAC_BITS + 1)) + {64'd0, TEN18};
    q = num / ({64'd0, TEN18} << 1);
    to_q35 = neg ? -$signed(q[63:0]) : $signed(q[63:0]);
  endfunction

  initial begin
    fail_count = 0;
    results_checked = 0;
    clip_count = 0;
    pending = 0;
    fb_coef[1] = to_q35(64'd4652613391863910000, 1'b1);
    fb_coef[2] = to_q35(64'd9141129478746480000, 1'b0);
    fb_coef[3] = to_q35(64'd9688720723376300000, 1'b1);
    fb_coef[4] = to_q35(64'd5834464028965880000, 1'b0);
    fb_coef[5] = to_q35(64'd1890599598988710000, 1'b1);
    fb_coef[6] = to_q35(64'd257315928152397000, 1'b0);
    ff_coef[0] = to_q35(64'd15245650559915, 1'b0);
    ff_coef[1] = to_q35(64'd91473903359488, 1'b0);
    ff_coef[2] = to_q35(64'd228684758398720, 1'b0);
    ff_coef[3] = to_q35(64'd304913011198293, 1'b0);
    // numerator is symmetric
    ff_coef[4] = ff_coef[2];
    ff_coef[5] = ff_coef[1];
    ff_coef[6] = ff_coef[0];
    for (int k = 0; k < FILTER_ORDER; k++) begin
      x_hist[k] = '0;
      y_hist[k] = '0;
    end
  end

  // one filter step: exact sum, round to history precision, saturate, shift memory
  task automatic filter_step(input sample_t x, output filtered_t res);
    logic signed [127:0] acc;
    logic signed [127:0] xe;
    logic signed [127:0] ye;
    logic signed [127:0] ce;
    logic signed [127:0] y_new;
    logic signed [63:0]  t;
    logic signed [63:0]  q;
    logic                clip;
    xe = x;
    ce = ff_coef[0];
    acc = (xe * ce) <<< HIST_FRAC_BITS;
    for (int k = 1; k <= FILTER_ORDER; k++) begin
      xe = x_hist[k-1];
      ce = ff_coef[k];
      acc = acc + ((xe * ce) <<< HIST_FRAC_BITS);
      ye = y_hist[k-1];
      ce = fb_coef[k];
      acc = acc - ce * ye;
    end
    acc = (acc + (128'sd1 <<< (COEFF_FRAC_BITS - 1))) >>> COEFF_FRAC_BITS;
    clip = 1'b0;
    y_new = acc;
    if (acc > HIST_TOP) begin
      y_new = HIST_TOP;
      clip = 1'b1;
    end else if (acc < HIST_BOTTOM) begin
      y_new = HIST_BOTTOM;
      clip = 1'b1;
    end
    for (int k = FILTER_ORDER - 1; k > 0; k--) begin
      x_hist[k] = x_hist[k-1];
      y_hist[k] = y_hist[k-1];
    end
    x_hist[0] = x;
    y_hist[0] = y_new[47:0];
    // integer output: round half up, then clamp to 16 bits
    t = $signed(y_new[63:0]) + (64'sd1 <<< (HIST_FRAC_BITS - 1));
    q = t >>> HIST_FRAC_BITS;
    if (q > OUT_TOP) begin
      q = OUT_TOP;
      clip = 1'b1;
    end else if (q < OUT_BOTTOM) begin
      q = OUT_BOTTOM;
      clip = 1'b1;
    end
    res.value = q[15:0];
    res.clipped = clip;
  endtask

  task automatic report_mismatch(input string msg);
    if (fail_count < 20) $display("%0t mismatch: %s", $time, msg);
    fail_count++;
  endtask

  // results first, then new items
  always @(posedge clk) begin : watch
    filtered_t want;
    filtered_t next_due;
    if (!rst_n) begin
      due_samples.delete();
      for (int k = 0; k < FILTER_ORDER; k++) begin
        x_hist[k] = '0;
        y_hist[k] = '0;
      end
    end else begin
      if (out_valid && !out_stall) begin
        if (due_samples.size() == 0) begin
          report_mismatch($sformatf("result %0d with nothing due", out_sample_out));
        end else begin
          want = due_samples.pop_front();
          results_checked++;
          if (want.clipped) clip_count++;
          if (out_sample_out !== want.value)
            report_mismatch($sformatf("item %0d sample_out %0d, want %0d",
                                      results_checked, out_sample_out, want.value));
          if (out_clipped !== want.clipped)
            report_mismatch($sformatf("item %0d clipped %b, want %b",
                                      results_checked, out_clipped, want.clipped));
        end
      end
      if (in_valid && !in_stall) begin
        filter_step(in_sample_in, next_due);
        due_samples.push_back(next_due);
      end
    end
    pending = due_samples.size();
  end

endmodule

// File: dv/tb_top.sv
// Testbench top for iir_lowpass_order6: clock, reset, sample stimulus, output stall
// and verdict. Depends on iir6_pkg, the block and iir6_checker.
`timescale 1ns / 100ps
module tb_top;
  import iir6_pkg::*;

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    in_valid = 1'b0;
  logic    in_stall;
  sample_t in_sample_in = '0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  sample_t out_sample_out;
  logic    out_clipped;

  int fail_count;
  int pending;
  int results_checked;
  int clip_count;

  int idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_left = 0;
  int sent_count = 0;

  iir_lowpass_order6 dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample_out (out_sample_out),
    .out_clipped    (out_clipped)
  );

  iir6_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample_in    (in_sample_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_sample_out  (out_sample_out),
    .out_clipped     (out_clipped),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_checked (results_checked),
    .clip_count      (clip_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // output side: random stall, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  function automatic sample_t clamp16(input int v);
    if (v > 32767) return sample_t'(32767);
    if (v < -32768) return sample_t'(-32768);
    return sample_t'(v);
  endfunction

  // offer one item after a random gap, hold it until taken
  task automatic send_sample(input sample_t v);
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_sample_in <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
  endtask

  // stop offering and wait until every due sample has come out
  task automatic drain_results;
    @(negedge clk);
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // one stretch of signal: rail-to-rail square wave, sweep, small noise or full noise
  task automatic play_segment(input int count);
    int kind;
    int level;
    int slope;
    int run_left;
    int v;
    kind = $urandom_range(0, 9);
    level = $urandom_range(0, 1) ? 32767 : -32768;
    slope = $urandom_range(0, 4000) - 2000;
    run_left = $urandom_range(0, 60);
    v = $urandom_range(0, 65535) - 32768;
    for (int i = 0; i < count; i++) begin
      if (kind < 5) begin
        // full swings overshoot and drive the output into saturation
        if (run_left == 0) begin
          level = (level >= 0) ? -32768 + $urandom_range(0, 3000)
                               : 32767 - $urandom_range(0, 3000);
          run_left = $urandom_range(20, 140);
        end
        run_left--;
        v = level + $urandom_range(0, 64) - 32;
      end else if (kind < 7) begin
        v = v + slope;
        if (v > 32767 || v < -32768) slope = -slope;
      end else if (kind < 9) begin
        v = $urandom_range(0, 511) - 256;
      end else begin
        v = $urandom_range(0, 65535) - 32768;
      end
      send_sample(clamp16(v));
    end
  endtask

  task automatic run_phase(input int items, input int idle, input int stall);
    int left;
    int n;
    idle_pct = idle;
    stall_pct = stall;
    left = items;
    while (left > 0) begin
      n = $urandom_range(30, 120);
      if (n > left) n = left;
      play_segment(n);
      left -= n;
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // extremes, sign boundaries and alternating bit patterns
    send_sample(sample_t'(0));
    send_sample(sample_t'(32767));
    send_sample(sample_t'(32767));
    send_sample(sample_t'(-32768));
    send_sample(sample_t'(-32768));
    send_sample(sample_t'(1));
    send_sample(sample_t'(-1));
    send_sample(sample_t'(16'h5555));
    send_sample(sample_t'(16'hAAAA));
    send_sample(sample_t'(16'h7FFE));
    send_sample(sample_t'(16'h8001));
    send_sample(sample_t'(256));
    send_sample(sample_t'(-256));
    send_sample(sample_t'(16'h00FF));
    send_sample(sample_t'(16'hFF00));
    send_sample(sample_t'(0));
    drain_results();

    // receiver holds off for a long stretch while items keep coming
    hold_req = 300;
    run_phase(160, 0, 0);
    drain_results();
    run_phase(160, 78, 0);
    run_phase(160, 0, 78);
    drain_results();
    run_phase(160, 17, 17);

    drain_results();
    repeat (30) @(posedge clk);
    $display("covered %0d samples in, %0d filtered samples checked, %0d saturated",
             sent_count, results_checked, clip_count);
    $display("idle and stall mixes: none, sender 78%%, receiver 78%%, both 17%%");
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("timeout with %0d samples still due", pending);
    $display("TB_ERROR");
    $finish;
  end

endmodule
